// ===== design/npn_truth_table_transform_assert.svh =====
// Assertion macros for the NPN truth table transform checker.
// No dependencies; included by the checker file only.
`ifndef NPN_TRUTH_TABLE_TRANSFORM_ASSERT_SVH
`define NPN_TRUTH_TABLE_TRANSFORM_ASSERT_SVH

// Same-cycle implication, sampled on clk, disabled while rst is high.
`define NPNTT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, disabled while rst is high.
`define NPNTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/npntt_pkg.sv =====
// Shared types, constants and table functions for the NPN transform.
// No dependencies; imported by every module of the block.
package npntt_pkg;

  localparam int MAX_INPUTS = 6;
  localparam int TABLE_W    = 64;
  localparam int VAR_W      = 3;

  localparam logic [VAR_W-1:0] VAR_COUNT_RESET = 3'd6;
  localparam logic [VAR_W-1:0] VAR_COUNT_MAX   = 3'(MAX_INPUTS);

  typedef logic [TABLE_W-1:0] table_t;
  typedef logic [VAR_W-1:0]   var_idx_t;

  // Control for the input/output negation step.
  typedef struct packed {
    logic [MAX_INPUTS-1:0] negate;
    logic                  complement;
  } neg_ctrl_t;

  // Control for one variable swap step.
  typedef struct packed {
    logic     active;
    var_idx_t var_idx;
    var_idx_t partner;
  } swap_ctrl_t;

  // Positions where variable v is 1; zero for codes past the last variable.
  function automatic table_t var_mask(var_idx_t v);
    table_t m;
    case (v)
      3'd0:    m = 64'hAAAA_AAAA_AAAA_AAAA;
      3'd1:    m = 64'hCCCC_CCCC_CCCC_CCCC;
      3'd2:    m = 64'hF0F0_F0F0_F0F0_F0F0;
      3'd3:    m = 64'hFF00_FF00_FF00_FF00;
      3'd4:    m = 64'hFFFF_0000_FFFF_0000;
      3'd5:    m = 64'hFFFF_FFFF_0000_0000;
      default: m = '0;
    endcase
    return m;
  endfunction

  // Valid table bits for n inputs (n already limited to MAX_INPUTS).
  function automatic table_t table_mask(var_idx_t n);
    table_t m;
    case (n)
      3'd0:    m = 64'h0000_0000_0000_0001;
      3'd1:    m = 64'h0000_0000_0000_0003;
      3'd2:    m = 64'h0000_0000_0000_000F;
      3'd3:    m = 64'h0000_0000_0000_00FF;
      3'd4:    m = 64'h0000_0000_0000_FFFF;
      3'd5:    m = 64'h0000_0000_FFFF_FFFF;
      default: m = '1;
    endcase
    return m;
  endfunction

  // Negate variable v: swap the halves that differ in v.
  function automatic table_t flip_var(table_t f, var_idx_t v, table_t tm);
    table_t   m;
    logic [5:0] s;
    m = var_mask(v) & tm;
    s = 6'd1 << v;
    return (((f & m) >> s) | ((f & ~m & tm) << s)) & tm;
  endfunction

  // Exchange variables a and b by a delta swap.
  function automatic table_t swap_vars(table_t f, var_idx_t a, var_idx_t b,
                                       table_t tm);
    var_idx_t   hi;
    var_idx_t   lo;
    logic [5:0] s;
    table_t     up;
    table_t     down;
    if (a == b) begin
      return f;
    end
    hi   = (a > b) ? a : b;
    lo   = (a > b) ? b : a;
    s    = (6'd1 << hi) - (6'd1 << lo);
    up   = ~var_mask(hi) & var_mask(lo) & tm;
    down = var_mask(hi) & ~var_mask(lo) & tm;
    return ((f & ~(up | down)) | ((f & up) << s) | ((f & down) >> s)) & tm;
  endfunction

endpackage

// ===== design/npntt_negate.sv =====
// Input negation and output complement stage of the NPN transform.
// Depends on npntt_pkg.
module npntt_negate import npntt_pkg::*; (
  input  table_t    table_in,
  input  table_t    tm,
  input  neg_ctrl_t ctrl,
  output table_t    table_out
);

  always_comb begin
    table_t f;
    f = table_in & tm;
    for (int v = 0; v < MAX_INPUTS; v++) begin
      if (ctrl.negate[v]) begin
        f = flip_var(f, 3'(v), tm);
      end
    end
    if (ctrl.complement) begin
      f = ~f & tm;
    end
    table_out = f;
  end

endmodule

// ===== design/npntt_swap.sv =====
// One variable exchange step of the NPN transform.
// Depends on npntt_pkg.
module npntt_swap import npntt_pkg::*; (
  input  table_t     table_in,
  input  table_t     tm,
  input  swap_ctrl_t ctrl,
  output table_t     table_out
);

  assign table_out = ctrl.active ? swap_vars(table_in, ctrl.var_idx, ctrl.partner, tm)
                                 : table_in;

endmodule

// ===== design/npn_truth_table_transform.sv =====
// NPN truth table transform, top level: input register, single-pass logic, result register.
// Depends on npntt_pkg, npntt_negate and npntt_swap.
//
// Takes the truth table of a function of up to six inputs and applies an
// NPN transform: selected inputs negated (variable 0 upward), then optional
// output complement, then for i = 0..n-1 variable i exchanged with perm_i.
// n comes from the variable count register (written through cfg_wr_en /
// cfg_wr_data, reset 6, codes above 6 act as 6). Table bits at and above 2^n
// read as zero. If any used perm entry is not below n, the result is a zero
// table with bad_permutation set. Timing: one item per clock sustained while
// out_ready stays high; a result passes through the input register and then
// the result register before it shows on the output. The result register
// frees itself whenever out_ready is high, so in_ready stays high while the
// output side keeps taking results. Write the variable count only while no
// item is in flight.
module npn_truth_table_transform import npntt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] truth_table,
  input  logic [5:0]  negate_inputs,
  input  logic        negate_output,
  input  logic [2:0]  perm_0,
  input  logic [2:0]  perm_1,
  input  logic [2:0]  perm_2,
  input  logic [2:0]  perm_3,
  input  logic [2:0]  perm_4,
  input  logic [2:0]  perm_5,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] result_table,
  output logic        bad_permutation
);

  // Configuration register
  var_idx_t var_count;
  var_idx_t n_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      var_count <= VAR_COUNT_RESET;
    end else if (cfg_wr_en) begin
      var_count <= cfg_wr_data;
    end
  end

  assign n_eff = (var_count > VAR_COUNT_MAX) ? VAR_COUNT_MAX : var_count;

  // Input register stage
  logic                  s1_valid;
  logic                  s1_ready;
  table_t                s1_table;
  logic [MAX_INPUTS-1:0] s1_neg;
  logic                  s1_negout;
  var_idx_t              s1_perm [MAX_INPUTS];

  // Stage 1 moves on when the result register is empty or being drained.
  assign s1_ready = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // Payload loads on every input transfer; no reset needed.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_table   <= truth_table;
      s1_neg     <= negate_inputs;
      s1_negout  <= negate_output;
      s1_perm[0] <= perm_0;
      s1_perm[1] <= perm_1;
      s1_perm[2] <= perm_2;
      s1_perm[3] <= perm_3;
      s1_perm[4] <= perm_4;
      s1_perm[5] <= perm_5;
    end
  end

  // Transform logic
  table_t    tm;
  logic      bad;
  neg_ctrl_t neg_ctrl;
  table_t    chain [MAX_INPUTS+1];

  assign tm = table_mask(n_eff);

  // Only entries of variables below n count, both for negation and checking.
  always_comb begin
    bad = 1'b0;
    for (int i = 0; i < MAX_INPUTS; i++) begin
      neg_ctrl.negate[i] = s1_neg[i] && (3'(i) < n_eff);
      if ((3'(i) < n_eff) && (s1_perm[i] >= n_eff)) begin
        bad = 1'b1;
      end
    end
    neg_ctrl.complement = s1_negout;
  end

  npntt_negate u_negate (
    .table_in  (s1_table),
    .tm        (tm),
    .ctrl      (neg_ctrl),
    .table_out (chain[0])
  );

  // Swap i with perm_i, in order; each step sees the previous result.
  for (genvar g = 0; g < MAX_INPUTS; g++) begin : g_swap
    swap_ctrl_t swap_ctrl;

    assign swap_ctrl.active  = 3'(g) < n_eff;
    assign swap_ctrl.var_idx = 3'(g);
    assign swap_ctrl.partner = s1_perm[g];

    npntt_swap u_swap (
      .table_in  (chain[g]),
      .tm        (tm),
      .ctrl      (swap_ctrl),
      .table_out (chain[g+1])
    );
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      result_table    <= bad ? '0 : chain[MAX_INPUTS];
      bad_permutation <= bad;
    end
  end

endmodule

// ===== design/npntt_checker.sv =====
// Port-level checker for the NPN truth table transform, bound to the top level.
// Depends on npn_truth_table_transform_assert.svh.
`include "npn_truth_table_transform_assert.svh"

module npntt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] result_table,
  input logic        bad_permutation
);

  logic [64:0] out_word;
  logic        in_xfer;

  assign out_word = {result_table, bad_permutation};
  assign in_xfer  = in_valid && in_ready;

  // A flagged permutation always comes with an empty table.
  `NPNTT_ASSERT_NOW(a_bad_zero, out_valid && bad_permutation, result_table == 64'd0, "bad flag, table set")

  // A stalled result holds.
  `NPNTT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word), "stall lost")

  // Input side never stalls while the output side can drain.
  `NPNTT_ASSERT_NOW(a_in_ready, !out_valid || out_ready, in_ready, "input stalled, slot free")

  // An accepted item with a draining output shows up once it has passed the input and result registers.
  `NPNTT_ASSERT_NEXT(a_latency, $past(in_xfer && !rst) && out_ready, out_valid, "result missing")

endmodule

bind npn_truth_table_transform npntt_checker u_checker (.*);

// ===== tb/npn_truth_table_transform_checker.sv =====
// Checker for the NPN truth table transform: watches both channels and the config port,
// predicts each result bit by bit and compares it. Depends on npntt_pkg.
`timescale 1ns / 1ps

module npn_truth_table_transform_checker import npntt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [63:0] truth_table,
  input  logic [5:0]  negate_inputs,
  input  logic        negate_output,
  input  logic [2:0]  perm_0,
  input  logic [2:0]  perm_1,
  input  logic [2:0]  perm_2,
  input  logic [2:0]  perm_3,
  input  logic [2:0]  perm_4,
  input  logic [2:0]  perm_5,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] result_table,
  input  logic        bad_permutation,
  output int          fail_count,
  output int          outstanding
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    table_t tbl;
    logic   bad;
  } npn_result_t;

  npn_result_t pending_images[$];
  var_idx_t    var_count_code = VAR_COUNT_RESET;
  int          mismatches = 0;

  // Works on table indexes: negating variable v reads bit k^(1<<v), swapping
  // variables a and b reads the bit whose index has bits a and b exchanged.
  function automatic npn_result_t npn_image(table_t tt, logic [5:0] neg, logic nout,
                                            logic [5:0][2:0] perm, var_idx_t code);
    npn_result_t r;
    table_t      f;
    table_t      g;
    int          n;
    int          span;
    int          i;
    int          k;
    int          a;
    int          b;
    int          src;
    n    = (code > VAR_COUNT_MAX) ? MAX_INPUTS : int'(code);
    span = 1 << n;
    r    = '0;
    for (i = 0; i < n; i++) begin
      if (int'(perm[i]) >= n) r.bad = 1'b1;
    end
    if (r.bad) begin
      return r;
    end
    f = '0;
    for (k = 0; k < span; k++) f[k] = tt[k];
    for (i = 0; i < n; i++) begin
      if (neg[i]) begin
        g = '0;
        for (k = 0; k < span; k++) g[k] = f[k ^ (1 << i)];
        f = g;
      end
    end
    if (nout) begin
      for (k = 0; k < span; k++) f[k] = ~f[k];
    end
    for (i = 0; i < n; i++) begin
      a = i;
      b = int'(perm[i]);
      g = '0;
      for (k = 0; k < span; k++) begin
        src = k & ~((1 << a) | (1 << b));
        src = src | (((k >> a) & 1) << b);
        src = src | (((k >> b) & 1) << a);
        g[k] = f[src];
      end
      f = g;
    end
    r.tbl = f;
    return r;
  endfunction

  always @(posedge clk) begin
    npn_result_t want;
    if (rst) begin
      var_count_code = VAR_COUNT_RESET;
      pending_images.delete();
    end else begin
      if (in_valid && in_ready) begin
        pending_images.insert(pending_images.size(),
          npn_image(truth_table, negate_inputs, negate_output,
                    {perm_5, perm_4, perm_3, perm_2, perm_1, perm_0}, var_count_code));
      end
      if (out_valid && out_ready) begin
        if (pending_images.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: unexpected result table %h flag %b", $realtime,
                     result_table, bad_permutation);
          end
        end else begin
          want = pending_images.pop_front();
          if (result_table !== want.tbl || bad_permutation !== want.bad) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: mismatch table exp %h got %h, flag exp %b got %b",
                       $realtime, want.tbl, result_table, want.bad, bad_permutation);
            end
          end
        end
      end
      if (cfg_wr_en) var_count_code = cfg_wr_data;
    end
    fail_count  <= mismatches;
    outstanding <= pending_images.size();
  end

endmodule

// ===== tb/npn_truth_table_transform_tb.sv =====
// Top of the NPN truth table transform testbench: clock, reset, stimulus, idling and verdict.
// Depends on npntt_pkg, the block and npn_truth_table_transform_checker.
`timescale 1ns / 1ps

module npn_truth_table_transform_tb import npntt_pkg::*;;

  typedef logic [5:0][2:0] perm_vec_t;

  // perm_vec_t literals list entry 5 first
  localparam perm_vec_t PERM_IDENTITY = {3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
  localparam perm_vec_t PERM_REVERSED = {3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5};
  localparam int        PHASES        = 9;
  localparam int        RANDOM_ITEMS  = 190;   // per phase
  localparam int        BLOCK_ITEMS   = 40;    // idling mode redrawn per block
  localparam int        MAX_WAIT      = 8;
  localparam int        DRAIN_CYCLES  = 4;     // result passes the input and result registers
  localparam int        STALL_LIMIT   = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] truth_table = '0;
  logic [5:0]  negate_inputs = '0;
  logic        negate_output = 1'b0;
  logic [2:0]  perm_0 = '0;
  logic [2:0]  perm_1 = '0;
  logic [2:0]  perm_2 = '0;
  logic [2:0]  perm_3 = '0;
  logic [2:0]  perm_4 = '0;
  logic [2:0]  perm_5 = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] result_table;
  logic        bad_permutation;

  int          fail_count;
  int          outstanding;
  int          quiet_cycles = 0;
  // while set, neither side inserts gaps or stalls
  logic        steady = 1'b0;

  always #5 clk = ~clk;

  npn_truth_table_transform i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .truth_table     (truth_table),
    .negate_inputs   (negate_inputs),
    .negate_output   (negate_output),
    .perm_0          (perm_0),
    .perm_1          (perm_1),
    .perm_2          (perm_2),
    .perm_3          (perm_3),
    .perm_4          (perm_4),
    .perm_5          (perm_5),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .result_table    (result_table),
    .bad_permutation (bad_permutation)
  );

  npn_truth_table_transform_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .truth_table     (truth_table),
    .negate_inputs   (negate_inputs),
    .negate_output   (negate_output),
    .perm_0          (perm_0),
    .perm_1          (perm_1),
    .perm_2          (perm_2),
    .perm_3          (perm_3),
    .perm_4          (perm_4),
    .perm_5          (perm_5),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .result_table    (result_table),
    .bad_permutation (bad_permutation),
    .fail_count      (fail_count),
    .outstanding     (outstanding)
  );

  // Offers one item after a random gap and returns at the edge of its transfer.
  // in_valid is left high so a back-to-back item never drops it.
  task automatic send_item(input table_t tt, input logic [5:0] neg, input logic nout,
                           input perm_vec_t p);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(MAX_WAIT, 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    truth_table   <= tt;
    negate_inputs <= neg;
    negate_output <= nout;
    perm_0        <= p[0];
    perm_1        <= p[1];
    perm_2        <= p[2];
    perm_3        <= p[3];
    perm_4        <= p[4];
    perm_5        <= p[5];
    in_valid      <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Output side: a fresh random stall before every result, none while steady is set.
  initial begin
    int unsigned hold;
    forever begin
      hold = steady ? 0 : $urandom_range(MAX_WAIT, 0);
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog: ends the run once nothing has moved for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    // variable count codes per phase: phase 0 runs on the reset value, then 1,
    // 0, 7 (saturates to 6), 2..5 and back to 6. Index 0 is the rightmost entry.
    logic [PHASES-1:0][2:0] plan;
    int          ph;
    int          j;
    int          i;
    int          n_eff;
    int unsigned pick;
    table_t      tt;
    perm_vec_t   p;

    plan = {3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd7, 3'd0, 3'd1, 3'd6};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (ph = 0; ph < PHASES; ph++) begin
      n_eff = (plan[ph] > VAR_COUNT_MAX) ? MAX_INPUTS : int'(plan[ph]);

      // config only changes with the pipeline empty
      if (ph != 0) begin
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= plan[ph];
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
      end

      if (ph == 0) begin
        // six inputs: field extremes, every negation, reordering and a few
        // out-of-range entries in the first and last used slots
        send_item('0, 6'h00, 1'b0, PERM_IDENTITY);
        send_item('1, 6'h3F, 1'b1, PERM_IDENTITY);
        send_item(64'h0000_0000_0000_0001, 6'h3F, 1'b0, PERM_IDENTITY);
        send_item(64'h8000_0000_0000_0000, 6'h00, 1'b0, PERM_REVERSED);
        send_item(64'h0123_4567_89AB_CDEF, 6'h15, 1'b1,
                  {3'd0, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1});
        send_item(64'h0123_4567_89AB_CDEF, 6'h2A, 1'b0,
                  {3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5});
        send_item(64'hDEAD_BEEF_F00D_CAFE, 6'h2A, 1'b1, '0);
        send_item(64'hDEAD_BEEF_F00D_CAFE, 6'h00, 1'b0,
                  {3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd6});
        send_item('1, 6'h3F, 1'b1, {3'd7, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0});
        send_item(64'h5555_AAAA_3333_CCCC, 6'h01, 1'b0, '1);
      end else begin
        // used entries reversed, unused ones at 7 and every negate bit set:
        // the block must ignore what lies beyond n
        p = '1;
        for (i = 0; i < n_eff; i++) p[i] = 3'(n_eff - 1 - i);
        send_item(64'h0123_4567_89AB_CDEF, 6'h3F, 1'b1, p);
        // top used entry exactly n: flagged. With n = 0 nothing is used and
        // all-7 entries must pass unflagged
        p = (n_eff == 0) ? perm_vec_t'('1) : PERM_IDENTITY;
        if (n_eff != 0) p[n_eff-1] = 3'(n_eff);
        send_item(64'h5555_5555_5555_5555, 6'h00, 1'b0, p);
      end

      for (j = 0; j < RANDOM_ITEMS; j++) begin
        if (j % BLOCK_ITEMS == 0) steady <= ($urandom_range(3, 0) == 0);
        pick = $urandom_range(15, 0);
        tt   = {$urandom, $urandom};
        if (pick == 0) tt = '0;
        else if (pick == 1) tt = '1;
        for (i = 0; i < 6; i++) p[i] = 3'($urandom_range(7, 0));
        // mostly a valid permutation on the used slots so the transform runs;
        // the rest keep raw entries and mostly hit the bad-permutation path
        if (n_eff != 0 && $urandom_range(9, 0) != 0) begin
          for (i = 0; i < n_eff; i++) p[i] = 3'($urandom_range(n_eff - 1, 0));
        end
        send_item(tt, 6'($urandom_range(63, 0)), 1'($urandom_range(1, 0)), p);
      end

      // drain: the checker's outstanding count is registered; wait until it reaches zero
      in_valid <= 1'b0;
      @(posedge clk);
      while (outstanding != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
